[src/assert_macros.svh]
// Assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define CHK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[src/tns_pkg.sv]
`default_nettype none

package tns_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_LOAD = 2'd1,
        FUNC_PLAY = 2'd2,
        FUNC_STOP = 2'd3
    } func_t;

    typedef enum logic {
        REG_ENABLE  = 1'b0,
        REG_CEILING = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_PLAY_MUL,
        ST_PLAY_NOTE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic cfg_we;
        logic tick_step;
        logic play_mul;
        logic play_note;
        logic out_load;
        logic addr_next;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  active;
        logic  play_ok;
        logic  step_more;
        logic  out_free;
    } stat_t;

    localparam logic [7:0]  CEILING_RESET = 8'd141;
    localparam logic [6:0]  VOL_MAX       = 7'd100;
    localparam logic [14:0] LVL_ROUND     = 15'd50;
    localparam logic [15:0] DIV_RECIP     = 16'd41944;
    localparam int          DIV_SHIFT     = 22;
    localparam int          CNT_W         = 6;
    localparam int          CNT_MAX       = 63;

endpackage

`default_nettype wire

[src/tns_ram.sv]
`default_nettype none

module tns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[src/tns_ctrl.sv]
`default_nettype none

module tns_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           cfg_valid,
    input  wire tns_pkg::stat_t stat,
    output tns_pkg::cmd_t       cmd,
    output logic                s_ready,
    output logic                cfg_ready
);
    import tns_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        cfg_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready  = 1'b1;
                cmd.cfg_we = cfg_valid;
                s_ready    = !cfg_valid;
                cmd.accept = s_valid && !cfg_valid;
                if (cmd.accept) begin
                    unique case (stat.func)
                        FUNC_TICK: state_next = stat.active ? ST_TICK : ST_DONE;
                        FUNC_PLAY: state_next = stat.play_ok ? ST_PLAY_MUL : ST_DONE;
                        FUNC_LOAD: state_next = ST_DONE;
                        FUNC_STOP: state_next = ST_DONE;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_TICK: begin
                cmd.tick_step = 1'b1;
                cmd.addr_next = 1'b1;
                if (!stat.step_more) begin
                    state_next = ST_DONE;
                end
            end
            ST_PLAY_MUL: begin
                cmd.play_mul = 1'b1;
                state_next   = ST_PLAY_NOTE;
            end
            ST_PLAY_NOTE: begin
                cmd.play_note = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                cmd.out_load = stat.out_free;
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

[src/tns_datapath.sv]
`default_nettype none

module tns_datapath #(
    parameter int MAX_NOTES = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tns_pkg::cmd_t  cmd,
    output tns_pkg::stat_t      stat,
    input  wire logic           cfg_index,
    input  wire logic [7:0]     cfg_data,
    input  wire logic [1:0]     s_func,
    input  wire logic [4:0]     s_note_index,
    input  wire logic [15:0]    s_note_pitch,
    input  wire logic [15:0]    s_note_length,
    input  wire logic [5:0]     s_note_count,
    input  wire logic [6:0]     s_cue_volume,
    input  wire logic [15:0]    s_tick_ms,
    input  wire logic           s_speaker_free,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic                m_tone_on,
    output logic [15:0]         m_tone_hz,
    output logic [7:0]          m_tone_level,
    output logic                m_speaker_held,
    output logic                m_playing
);
    import tns_pkg::*;

    localparam int AW  = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int PW  = (AW > CNT_W) ? AW : CNT_W;
    localparam int IW  = (AW > 5) ? AW : 5;
    localparam int CAP = (MAX_NOTES < CNT_MAX) ? MAX_NOTES : CNT_MAX;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

    logic             enable_reg,   enable_next;
    logic [7:0]       ceiling_reg,  ceiling_next;
    logic [CNT_W-1:0] cue_len_reg,  cue_len_next;
    logic [CNT_W-1:0] pos_reg,      pos_next;
    logic [16:0]      elapsed_reg,  elapsed_next;
    logic [7:0]       level_reg,    level_next;
    logic             active_reg,   active_next;
    logic             held_reg,     held_next;
    logic             sounding_reg, sounding_next;
    logic [15:0]      hz_reg,       hz_next;
    logic             free_reg,     free_next;
    logic             start_reg,    start_next;
    logic [14:0]      prod_reg,     prod_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_on_reg,    out_on_next;
    logic [15:0]      out_hz_reg,    out_hz_next;
    logic [7:0]       out_level_reg, out_level_next;
    logic             out_held_reg,  out_held_next;
    logic             out_play_reg,  out_play_next;

    logic [CNT_W-1:0] rd_pos;
    logic [PW-1:0]    rd_pos_ext;
    logic [IW-1:0]    wr_idx_ext;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             ram_we;
    logic [31:0]      rd_data;
    logic [15:0]      rd_pitch;
    logic [15:0]      rd_len;
    logic             fits;
    logic             last;
    logic [6:0]       vol_c;
    logic [5:0]       count_c;
    logic [30:0]      lvl_prod;
    logic             sn_held;
    logic             sn_sounding;
    logic [15:0]      sn_hz;
    func_t            func;

    assign func       = func_t'(s_func);
    assign rd_pos     = cmd.addr_next ? (pos_reg + 1'b1) : pos_reg;
    assign rd_pos_ext = PW'(rd_pos);
    assign rd_addr    = rd_pos_ext[AW-1:0];
    assign wr_idx_ext = IW'(s_note_index);
    assign wr_addr    = wr_idx_ext[AW-1:0];
    assign ram_we     = cmd.accept && (func == FUNC_LOAD) &&
                        (32'(s_note_index) < 32'(MAX_NOTES));
    assign rd_pitch   = rd_data[31:16];
    assign rd_len     = rd_data[15:0];

    tns_ram #(
        .WIDTH(32),
        .DEPTH(MAX_NOTES)
    ) u_store (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(wr_addr),
        .wdata({s_note_pitch, s_note_length}),
        .raddr(rd_addr),
        .rdata(rd_data)
    );

    assign fits     = elapsed_reg >= {1'b0, rd_len};
    assign last     = ({1'b0, pos_reg} + 7'd1) >= {1'b0, cue_len_reg};
    assign vol_c    = (s_cue_volume > VOL_MAX) ? VOL_MAX : s_cue_volume;
    assign count_c  = (s_note_count > CAP_CNT) ? CAP_CNT : s_note_count;
    assign lvl_prod = 31'(prod_reg) * 31'(DIV_RECIP);

    assign stat.func      = func;
    assign stat.active    = active_reg;
    assign stat.play_ok   = enable_reg && (s_note_count != '0);
    assign stat.step_more = fits && !last;
    assign stat.out_free  = !out_valid_reg || m_ready;

    // start of a note at the entry just read
    always_comb begin
        sn_held     = held_reg;
        sn_sounding = sounding_reg;
        sn_hz       = hz_reg;
        if (rd_pitch == '0) begin
            sn_sounding = 1'b0;
            sn_hz       = '0;
        end else if (held_reg || free_reg) begin
            sn_held     = 1'b1;
            sn_sounding = 1'b1;
            sn_hz       = rd_pitch;
        end
    end

    always_comb begin
        enable_next    = enable_reg;
        ceiling_next   = ceiling_reg;
        cue_len_next   = cue_len_reg;
        pos_next       = pos_reg;
        elapsed_next   = elapsed_reg;
        level_next     = level_reg;
        active_next    = active_reg;
        held_next      = held_reg;
        sounding_next  = sounding_reg;
        hz_next        = hz_reg;
        free_next      = free_reg;
        start_next     = start_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_on_next    = out_on_reg;
        out_hz_next    = out_hz_reg;
        out_level_next = out_level_reg;
        out_held_next  = out_held_reg;
        out_play_next  = out_play_reg;

        if (cmd.cfg_we) begin
            if (cfg_index == REG_ENABLE) begin
                enable_next = cfg_data[0];
                if (!cfg_data[0]) begin
                    active_next   = 1'b0;
                    cue_len_next  = '0;
                    pos_next      = '0;
                    elapsed_next  = '0;
                    held_next     = 1'b0;
                    sounding_next = 1'b0;
                    hz_next       = '0;
                end
            end else begin
                ceiling_next = cfg_data;
            end
        end

        if (cmd.accept) begin
            free_next  = s_speaker_free;
            start_next = 1'b0;
            unique case (func)
                FUNC_TICK: begin
                    if (!active_reg) begin
                        held_next     = 1'b0;
                        sounding_next = 1'b0;
                        hz_next       = '0;
                    end else begin
                        elapsed_next = elapsed_reg + {1'b0, s_tick_ms};
                    end
                end
                FUNC_LOAD: begin
                end
                FUNC_PLAY: begin
                    if (stat.play_ok) begin
                        cue_len_next = count_c;
                        pos_next     = '0;
                        elapsed_next = '0;
                        active_next  = 1'b1;
                        prod_next    = ({7'd0, ceiling_reg} * {8'd0, vol_c}) + LVL_ROUND;
                    end
                end
                FUNC_STOP: begin
                    active_next   = 1'b0;
                    cue_len_next  = '0;
                    pos_next      = '0;
                    elapsed_next  = '0;
                    held_next     = 1'b0;
                    sounding_next = 1'b0;
                    hz_next       = '0;
                end
                default: begin
                end
            endcase
        end

        if (cmd.tick_step) begin
            if (start_reg) begin
                held_next     = sn_held;
                sounding_next = sn_sounding;
                hz_next       = sn_hz;
            end
            if (fits) begin
                elapsed_next = elapsed_reg - {1'b0, rd_len};
                pos_next     = pos_reg + 1'b1;
                start_next   = 1'b1;
                if (last) begin
                    active_next   = 1'b0;
                    cue_len_next  = '0;
                    pos_next      = '0;
                    elapsed_next  = '0;
                    held_next     = 1'b0;
                    sounding_next = 1'b0;
                    hz_next       = '0;
                end
            end
        end

        if (cmd.play_mul) begin
            level_next = lvl_prod[DIV_SHIFT+7:DIV_SHIFT];
        end

        if (cmd.play_note) begin
            held_next     = sn_held;
            sounding_next = sn_sounding;
            hz_next       = sn_hz;
        end

        if (cmd.out_load) begin
            out_valid_next = 1'b1;
            out_on_next    = sounding_reg;
            out_hz_next    = sounding_reg ? hz_reg : '0;
            out_level_next = sounding_reg ? level_reg : '0;
            out_held_next  = held_reg;
            out_play_next  = active_reg;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg    <= 1'b1;
            ceiling_reg   <= CEILING_RESET;
            cue_len_reg   <= '0;
            pos_reg       <= '0;
            elapsed_reg   <= '0;
            level_reg     <= CEILING_RESET;
            active_reg    <= 1'b0;
            held_reg      <= 1'b0;
            sounding_reg  <= 1'b0;
            free_reg      <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            enable_reg    <= enable_next;
            ceiling_reg   <= ceiling_next;
            cue_len_reg   <= cue_len_next;
            pos_reg       <= pos_next;
            elapsed_reg   <= elapsed_next;
            level_reg     <= level_next;
            active_reg    <= active_next;
            held_reg      <= held_next;
            sounding_reg  <= sounding_next;
            free_reg      <= free_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hz_reg        <= hz_next;
        prod_reg      <= prod_next;
        out_on_reg    <= out_on_next;
        out_hz_reg    <= out_hz_next;
        out_level_reg <= out_level_next;
        out_held_reg  <= out_held_next;
        out_play_reg  <= out_play_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_tone_on      = out_on_reg;
    assign m_tone_hz      = out_hz_reg;
    assign m_tone_level   = out_level_reg;
    assign m_speaker_held = out_held_reg;
    assign m_playing      = out_play_reg;

endmodule

`default_nettype wire

[src/tone_note_sequencer.sv]
// Tone note sequencer: plays a cue of notes held in a note store.
// Request channel (s_*): func selects tick, load note, play or stop; one
// result per request on the m_* channel, giving the state after the request.
// Configuration channel (cfg_*): register 0 sound_enable (writing 0 stops the
// cue), register 1 volume_ceiling; written only while the block is idle.
// Load, stop, an idle tick or an ignored play go from acceptance straight to the
// done state; a play first passes the multiply and note states; a tick over an
// active cue passes the tick state, which evaluates one note per cycle through the
// single read port of the note store. One request is in flight at a time; the
// next is accepted once the previous result has entered the output register.
// Reset stops the cue, releases the speaker, enables sound and sets the
// ceiling to 141; the note store holds no defined contents until loaded.
// When the receiver stalls, the result waits in the output register and the
// following request is still accepted, but its result is held back until the
// register empties.
`default_nettype none

module tone_note_sequencer #(
    parameter int MAX_NOTES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_func,
    input  wire logic [4:0]  s_note_index,
    input  wire logic [15:0] s_note_pitch,
    input  wire logic [15:0] s_note_length,
    input  wire logic [5:0]  s_note_count,
    input  wire logic [6:0]  s_cue_volume,
    input  wire logic [15:0] s_tick_ms,
    input  wire logic        s_speaker_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_tone_on,
    output logic [15:0]      m_tone_hz,
    output logic [7:0]       m_tone_level,
    output logic             m_speaker_held,
    output logic             m_playing
);
    import tns_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .cfg_valid(cfg_valid),
        .stat     (stat),
        .cmd      (cmd),
        .s_ready  (s_ready),
        .cfg_ready(cfg_ready)
    );

    tns_datapath #(
        .MAX_NOTES(MAX_NOTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_func        (s_func),
        .s_note_index  (s_note_index),
        .s_note_pitch  (s_note_pitch),
        .s_note_length (s_note_length),
        .s_note_count  (s_note_count),
        .s_cue_volume  (s_cue_volume),
        .s_tick_ms     (s_tick_ms),
        .s_speaker_free(s_speaker_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_tone_on     (m_tone_on),
        .m_tone_hz     (m_tone_hz),
        .m_tone_level  (m_tone_level),
        .m_speaker_held(m_speaker_held),
        .m_playing     (m_playing)
    );

endmodule

`default_nettype wire

[src/tns_checker.sv]
`default_nettype none
`include "assert_macros.svh"

module tns_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_tone_on,
    input wire logic [15:0] m_tone_hz,
    input wire logic [7:0]  m_tone_level,
    input wire logic        m_speaker_held,
    input wire logic        m_playing
);

    `CHK_ASSERT(a_result_holds, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `CHK_ASSERT(a_tone_held, m_valid && m_tone_on |-> m_speaker_held && m_playing, "tone unheld")
    `CHK_ASSERT(a_mute, m_valid && !m_tone_on |-> !(|m_tone_hz) && !(|m_tone_level), "muted tone")
    `CHK_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result present after reset")

endmodule

bind tone_note_sequencer tns_checker u_tns_checker (.*);

`default_nettype wire

[tb/tone_note_sequencer_tb.sv]
`default_nettype none

module tone_note_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tns_pkg::*;

    localparam int NOTES       = 32;
    localparam int PHASE_ITEMS = 190;
    localparam int NOISE_ITEMS = 180;
    localparam int TAIL_CYCLES = 48;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        func_t       func;
        logic [4:0]  idx;
        logic [15:0] pitch;
        logic [15:0] span;
        logic [5:0]  count;
        logic [6:0]  volume;
        logic [15:0] tick_ms;
        logic        spk_free;
    } request_t;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] hz;
        logic [7:0]  level;
        logic        held;
        logic        playing;
    } tone_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_func;
    logic [4:0]  s_note_index;
    logic [15:0] s_note_pitch;
    logic [15:0] s_note_length;
    logic [5:0]  s_note_count;
    logic [6:0]  s_cue_volume;
    logic [15:0] s_tick_ms;
    logic        s_speaker_free;
    logic        m_valid;
    logic        m_ready;
    logic        m_tone_on;
    logic [15:0] m_tone_hz;
    logic [7:0]  m_tone_level;
    logic        m_speaker_held;
    logic        m_playing;

    logic [15:0] pitch_mem [NOTES];
    logic [15:0] span_mem [NOTES];
    bit          loaded [NOTES];
    int unsigned cue_len;
    int unsigned note_pos;
    int unsigned elapsed_ms;
    int unsigned drive_level;
    int unsigned ceiling;
    int unsigned live_hz;
    bit          cue_active;
    bit          spk_held;
    bit          tone_live;
    bit          snd_en;

    tone_t       tone_q [$];
    int unsigned sent_count = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;

    tone_note_sequencer dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_note_index   (s_note_index),
        .s_note_pitch   (s_note_pitch),
        .s_note_length  (s_note_length),
        .s_note_count   (s_note_count),
        .s_cue_volume   (s_cue_volume),
        .s_tick_ms      (s_tick_ms),
        .s_speaker_free (s_speaker_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tone_on      (m_tone_on),
        .m_tone_hz      (m_tone_hz),
        .m_tone_level   (m_tone_level),
        .m_speaker_held (m_speaker_held),
        .m_playing      (m_playing)
    );

    always #5ns aclk = ~aclk;

    function automatic void drop_speaker();
        spk_held  = 1'b0;
        tone_live = 1'b0;
        live_hz   = 0;
    endfunction

    function automatic void halt_cue();
        cue_active = 1'b0;
        cue_len    = 0;
        note_pos   = 0;
        elapsed_ms = 0;
        drop_speaker();
    endfunction

    function automatic void start_current_note(bit spk_free);
        int unsigned hz;
        if (note_pos >= cue_len || note_pos >= NOTES) return;
        hz = 32'(pitch_mem[note_pos]);
        if (hz == 0) begin
            tone_live = 1'b0;
            live_hz   = 0;
            return;
        end
        if (!spk_held) begin
            if (!spk_free) return;
            spk_held = 1'b1;
        end
        tone_live = 1'b1;
        live_hz   = hz;
    endfunction

    function automatic void apply_register(reg_idx_t which, logic [7:0] value);
        if (which == REG_ENABLE) begin
            snd_en = value[0];
            if (!snd_en) halt_cue();
        end else begin
            ceiling = 32'(value);
        end
    endfunction

    function automatic tone_t sequence_request(request_t r);
        tone_t       t;
        int unsigned vol;
        int unsigned count;
        case (r.func)
            FUNC_TICK: begin
                if (!cue_active) begin
                    drop_speaker();
                end else begin
                    elapsed_ms = (elapsed_ms + r.tick_ms) & 32'h1FFFF;
                    while (cue_active && note_pos < NOTES &&
                           elapsed_ms >= span_mem[note_pos]) begin
                        elapsed_ms -= 32'(span_mem[note_pos]);
                        note_pos++;
                        if (note_pos >= cue_len) halt_cue();
                        else start_current_note(r.spk_free);
                    end
                end
            end
            FUNC_LOAD: begin
                pitch_mem[r.idx] = r.pitch;
                span_mem[r.idx]  = r.span;
                loaded[r.idx]    = 1'b1;
            end
            FUNC_PLAY: begin
                if (snd_en && r.count != 0) begin
                    count       = (r.count > NOTES) ? NOTES : r.count;
                    vol         = 32'((r.volume > VOL_MAX) ? VOL_MAX : r.volume);
                    cue_len     = count;
                    note_pos    = 0;
                    elapsed_ms  = 0;
                    drive_level = ((ceiling * vol + LVL_ROUND) / VOL_MAX) & 8'hFF;
                    cue_active  = 1'b1;
                    start_current_note(r.spk_free);
                end
            end
            default: halt_cue();
        endcase
        t.tone_on = tone_live;
        t.hz      = tone_live ? live_hz[15:0] : 16'd0;
        t.level   = tone_live ? drive_level[7:0] : 8'd0;
        t.held    = spk_held;
        t.playing = cue_active;
        return t;
    endfunction

    // never start a cue over store entries that were never loaded
    function automatic logic [5:0] safe_count();
        int unsigned run;
        run = 0;
        while (run < NOTES && loaded[run]) run++;
        if (run == NOTES) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, run));
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.func     = func_t'($urandom_range(0, 3));
        r.idx      = 5'($urandom());
        r.pitch    = 16'($urandom());
        r.span     = 16'($urandom());
        r.count    = safe_count();
        r.volume   = 7'($urandom());
        r.tick_ms  = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                : 16'($urandom_range(0, 80));
        r.spk_free = 1'($urandom());
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s, expected %0d, got %0d", $time, field, want, got);
        error_count++;
    endtask

    task automatic send_request(input request_t r);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_func         <= r.func;
        s_note_index   <= r.idx;
        s_note_pitch   <= r.pitch;
        s_note_length  <= r.span;
        s_note_count   <= r.count;
        s_cue_volume   <= r.volume;
        s_tick_ms      <= r.tick_ms;
        s_speaker_free <= r.spk_free;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tone_q.push_back(sequence_request(r));
        sent_count++;
    endtask

    task automatic send_load(input int unsigned idx, input int unsigned pitch,
                             input int unsigned span);
        request_t r;
        r       = random_request();
        r.func  = FUNC_LOAD;
        r.idx   = 5'(idx);
        r.pitch = 16'(pitch);
        r.span  = 16'(span);
        send_request(r);
    endtask

    task automatic send_play(input int unsigned count, input int unsigned volume,
                             input bit spk_free);
        request_t r;
        r          = random_request();
        r.func     = FUNC_PLAY;
        r.count    = 6'(count);
        r.volume   = 7'(volume);
        r.spk_free = spk_free;
        send_request(r);
    endtask

    task automatic send_tick(input int unsigned ms, input bit spk_free);
        request_t r;
        r          = random_request();
        r.func     = FUNC_TICK;
        r.tick_ms  = 16'(ms);
        r.spk_free = spk_free;
        send_request(r);
    endtask

    task automatic send_stop();
        request_t r;
        r      = random_request();
        r.func = FUNC_STOP;
        send_request(r);
    endtask

    // hold off until every request has returned its result
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tone_q.size() != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic configure(input logic enable, input logic [7:0] ceil_val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_ENABLE;
        cfg_data  <= {7'd0, enable};
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_register(REG_ENABLE, {7'd0, enable});
        cfg_index <= REG_CEILING;
        cfg_data  <= ceil_val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_register(REG_CEILING, ceil_val);
        cfg_valid <= 1'b0;
    endtask

    task automatic play_random_cue();
        request_t    r;
        int unsigned notes;
        int unsigned ticks;
        notes = ($urandom_range(0, 7) == 0) ? NOTES : $urandom_range(1, 8);
        for (int unsigned i = 0; i < notes; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    send_load(i, ($urandom_range(0, 4) == 0) ? 0 : $urandom(), 0);
                2:       send_load(i, ($urandom_range(0, 4) == 0) ? 0 : $urandom(),
                                   $urandom());
                default: send_load(i, ($urandom_range(0, 4) == 0) ? 0 : $urandom(),
                                   $urandom_range(1, 40));
            endcase
        end
        send_play((notes == NOTES) ? $urandom_range(1, 63) : $urandom_range(1, notes),
                  $urandom_range(0, 127), $urandom_range(0, 3) != 0);
        ticks = 0;
        while (cue_active && ticks < 16) begin
            r          = random_request();
            r.spk_free = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 19))
                0:       r.func = FUNC_STOP;
                1:       ;
                default: r.func = FUNC_TICK;
            endcase
            send_request(r);
            ticks++;
        end
        send_tick($urandom_range(0, 80), 1'($urandom()));
    endtask

    task automatic test_special_cases();
        send_tick(0, 1'b1);
        send_load(0, 65535, 0);
        send_load(1, 0, 3);
        send_load(2, 1, 65535);
        send_load(31, 440, 10);
        send_play(0, 50, 1'b1);
        // speaker busy: first note skipped, cue keeps timing
        send_play(3, 127, 1'b0);
        send_tick(0, 1'b1);
        send_tick(3, 1'b0);
        send_stop();
        send_play(3, 100, 1'b1);
        send_tick(65535, 1'b1);
        send_tick(65535, 1'b1);
        send_tick(0, 1'b1);
        // rest keeps the speaker held
        send_play(2, 0, 1'b1);
        send_tick(0, 1'b0);
        send_tick(3, 1'b0);
        send_play(3, 50, 1'b1);
        send_tick(1, 1'b0);
        send_tick(2, 1'b0);
        send_stop();
        send_play(3, 100, 1'b1);
        configure(1'b0, 8'd255);
        send_play(3, 100, 1'b1);
        send_tick(5, 1'b1);
    endtask

    task automatic test_cue_sequences();
        logic [7:0]  ceil_val;
        int unsigned target;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0:       ceil_val = CEILING_RESET;
                1:       ceil_val = 8'd255;
                2:       ceil_val = 8'd0;
                5:       ceil_val = 8'd1;
                6:       ceil_val = 8'd100;
                default: ceil_val = 8'($urandom());
            endcase
            configure(ph != 3, ceil_val);
            steady = (ph % 3 == 1);
            target = sent_count + PHASE_ITEMS;
            while (sent_count < target) begin
                if ($urandom_range(0, 4) == 0) send_request(random_request());
                else play_random_cue();
            end
        end
    endtask

    task automatic test_random_noise();
        int unsigned target;
        configure(1'b1, 8'($urandom()));
        steady = 1'b0;
        target = sent_count + NOISE_ITEMS;
        while (sent_count < target) send_request(random_request());
    endtask

    initial begin : drive_result_ready
        int unsigned stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready));
        end
    end

    always @(posedge aclk) begin : check_result
        tone_t want;
        if (aresetn && m_valid && m_ready) begin
            if (tone_q.size() == 0) begin
                report_mismatch("result with no request pending", 0, 1);
            end else begin
                want = tone_q.pop_front();
                if (m_tone_on !== want.tone_on)
                    report_mismatch("tone_on", 32'(want.tone_on), 32'(m_tone_on));
                if (m_tone_hz !== want.hz)
                    report_mismatch("tone_hz", 32'(want.hz), 32'(m_tone_hz));
                if (m_tone_level !== want.level)
                    report_mismatch("tone_level", 32'(want.level), 32'(m_tone_level));
                if (m_speaker_held !== want.held)
                    report_mismatch("speaker_held", 32'(want.held), 32'(m_speaker_held));
                if (m_playing !== want.playing)
                    report_mismatch("playing", 32'(want.playing), 32'(m_playing));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tone_note_sequencer_tb: FAIL");
            $finish;
        end
    end

    initial begin
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= REG_ENABLE;
        cfg_data       <= 8'd0;
        s_valid        <= 1'b0;
        s_func         <= FUNC_TICK;
        s_note_index   <= 5'd0;
        s_note_pitch   <= 16'd0;
        s_note_length  <= 16'd0;
        s_note_count   <= 6'd0;
        s_cue_volume   <= 7'd0;
        s_tick_ms      <= 16'd0;
        s_speaker_free <= 1'b0;
        for (int i = 0; i < NOTES; i++) begin
            pitch_mem[i] = 16'd0;
            span_mem[i]  = 16'd0;
            loaded[i]    = 1'b0;
        end
        cue_len     = 0;
        note_pos    = 0;
        elapsed_ms  = 0;
        drive_level = 32'(CEILING_RESET);
        ceiling     = 32'(CEILING_RESET);
        live_hz     = 0;
        cue_active  = 1'b0;
        spk_held    = 1'b0;
        tone_live   = 1'b0;
        snd_en      = 1'b1;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_special_cases();
        test_cue_sequences();
        test_random_noise();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("tone_note_sequencer_tb: PASS");
        end else begin
            $display("tone_note_sequencer_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
